/* hdl/otel_pkg.sv */
// Shared types, codes and conversion constants for the over-temperature episode logger.
package otel_pkg;

  localparam int TEMP_W   = 9;
  localparam int ADC_W    = 12;
  localparam int SETV_W   = 8;
  localparam int SEC_W    = 6;
  localparam int MIN_W    = 6;
  localparam int HOUR_W   = 5;
  localparam int IDX_W    = 8;
  localparam int OP_W     = 3;
  localparam int SCALED_W = 28;
  localparam int DIFF_W   = 15;
  localparam int PROD_W   = 31;

  localparam logic [SCALED_W-1:0] CONV_SLOPE  = 28'd33000;
  localparam logic [SCALED_W-1:0] CONV_OFFSET = 28'd119705600;
  // floor(x / 93) == (x * 45101) >> 22 for every x below 2**15
  localparam logic [PROD_W-1:0]   CONV_RECIP  = 31'd45101;
  localparam int                  RECIP_SHIFT = 22;

  localparam logic [TEMP_W-1:0] THRESHOLD_RESET = 9'd40;
  localparam logic [SEC_W-1:0]  SEC_MAX  = 6'd59;
  localparam logic [MIN_W-1:0]  MIN_MAX  = 6'd59;
  localparam logic [HOUR_W-1:0] HOUR_MAX = 5'd23;

  typedef enum logic [OP_W-1:0] {
    OP_TICK      = 3'd0,
    OP_SET_SEC   = 3'd1,
    OP_SET_MIN   = 3'd2,
    OP_SET_HOUR  = 3'd3,
    OP_CLEAR_LOG = 3'd4
  } op_t;

  typedef struct packed {
    logic [TEMP_W-1:0] temp;
    logic              clamped;
  } conv_t;

  typedef struct packed {
    logic [IDX_W-1:0]  record_index;
    logic [TEMP_W-1:0] record_peak;
    logic              record_valid;
    logic [HOUR_W-1:0] clock_hours;
    logic [MIN_W-1:0]  clock_minutes;
    logic [SEC_W-1:0]  clock_seconds;
    logic              clamped_low;
    logic              over_threshold;
    logic [TEMP_W-1:0] temperature;
  } result_t;

endpackage

/* hdl/otel_convert.sv */
// Sample-to-degrees conversion: offset subtract, zero clamp, constant divide by reciprocal.
module otel_convert (
  input  logic [otel_pkg::SCALED_W-1:0] scaled,
  output otel_pkg::conv_t               conv
);

  logic [otel_pkg::SCALED_W-1:0] diff;
  logic [otel_pkg::DIFF_W-1:0]   coarse;
  logic [otel_pkg::PROD_W-1:0]   prod;
  logic                          negative;

  assign negative = scaled > otel_pkg::CONV_OFFSET;
  assign diff     = otel_pkg::CONV_OFFSET - scaled;
  // divide by 4096 first, then by 93
  assign coarse   = diff[otel_pkg::DIFF_W+11:12];
  assign prod     = otel_pkg::PROD_W'(coarse) * otel_pkg::CONV_RECIP;

  always_comb begin
    conv.clamped = negative;
    if (negative) begin
      conv.temp = '0;
    end else begin
      conv.temp = prod[otel_pkg::RECIP_SHIFT +: otel_pkg::TEMP_W];
    end
  end

endmodule

/* hdl/otel_episode.sv */
// Time-of-day counters, episode peak tracking and record numbering.
module otel_episode (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [otel_pkg::OP_W-1:0]   op,
  input  logic [otel_pkg::SETV_W-1:0] set_value,
  input  otel_pkg::conv_t             conv,
  input  logic [otel_pkg::TEMP_W-1:0] threshold,
  output otel_pkg::result_t           result
);

  logic [otel_pkg::SEC_W-1:0]  seconds_count, seconds_count_next;
  logic [otel_pkg::MIN_W-1:0]  minutes_count, minutes_count_next;
  logic [otel_pkg::HOUR_W-1:0] hours_count, hours_count_next;
  logic                        episode_active, episode_active_next;
  logic [otel_pkg::TEMP_W-1:0] episode_peak, episode_peak_next;
  logic [otel_pkg::IDX_W-1:0]  records_written, records_written_next;
  logic                        over;

  assign over = conv.temp >= threshold;

  always_comb begin
    seconds_count_next   = seconds_count;
    minutes_count_next   = minutes_count;
    hours_count_next     = hours_count;
    episode_active_next  = episode_active;
    episode_peak_next    = episode_peak;
    records_written_next = records_written;
    result               = '0;

    unique case (otel_pkg::op_t'(op))
      otel_pkg::OP_TICK: begin
        result.temperature    = conv.temp;
        result.clamped_low    = conv.clamped;
        result.over_threshold = over;
        if (seconds_count >= otel_pkg::SEC_MAX) begin
          seconds_count_next = '0;
          if (minutes_count >= otel_pkg::MIN_MAX) begin
            minutes_count_next = '0;
            if (hours_count >= otel_pkg::HOUR_MAX) begin
              hours_count_next = '0;
            end else begin
              hours_count_next = hours_count + 1'b1;
            end
          end else begin
            minutes_count_next = minutes_count + 1'b1;
          end
        end else begin
          seconds_count_next = seconds_count + 1'b1;
        end
        if (over) begin
          if (!episode_active || conv.temp > episode_peak) begin
            episode_peak_next = conv.temp;
          end
          episode_active_next = 1'b1;
        end else if (episode_active) begin
          result.record_valid  = 1'b1;
          result.record_peak   = episode_peak;
          result.record_index  = records_written;
          records_written_next = records_written + 1'b1;
          episode_active_next  = 1'b0;
          episode_peak_next    = '0;
        end
      end
      otel_pkg::OP_SET_SEC: begin
        if (set_value > otel_pkg::SETV_W'(otel_pkg::SEC_MAX)) begin
          seconds_count_next = otel_pkg::SEC_MAX;
        end else begin
          seconds_count_next = set_value[otel_pkg::SEC_W-1:0];
        end
      end
      otel_pkg::OP_SET_MIN: begin
        if (set_value > otel_pkg::SETV_W'(otel_pkg::MIN_MAX)) begin
          minutes_count_next = otel_pkg::MIN_MAX;
        end else begin
          minutes_count_next = set_value[otel_pkg::MIN_W-1:0];
        end
      end
      otel_pkg::OP_SET_HOUR: begin
        if (set_value > otel_pkg::SETV_W'(otel_pkg::HOUR_MAX)) begin
          hours_count_next = otel_pkg::HOUR_MAX;
        end else begin
          hours_count_next = set_value[otel_pkg::HOUR_W-1:0];
        end
      end
      otel_pkg::OP_CLEAR_LOG: begin
        records_written_next = '0;
      end
      default: begin
      end
    endcase

    result.clock_seconds = seconds_count_next;
    result.clock_minutes = minutes_count_next;
    result.clock_hours   = hours_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seconds_count   <= '0;
      minutes_count   <= '0;
      hours_count     <= '0;
      episode_active  <= 1'b0;
      episode_peak    <= '0;
      records_written <= '0;
    end else if (step) begin
      seconds_count   <= seconds_count_next;
      minutes_count   <= minutes_count_next;
      hours_count     <= hours_count_next;
      episode_active  <= episode_active_next;
      episode_peak    <= episode_peak_next;
      records_written <= records_written_next;
    end
  end

endmodule

/* hdl/over_temperature_episode_logger_core.sv */
// Top level of the over-temperature episode logger: input stage, result stage, threshold.
//
//  channel    | direction | fields
//  s_* stream | in        | tuser: operation; tdata: adc_sample, set_value
//  m_* stream | out       | tuser: record_valid; tdata: temperature .. record_index
//  threshold  | in        | alarm_threshold_we / alarm_threshold_wdata
//
// One transfer per cycle sustained while m_tready is high; the input register loads on
// the input transfer, the result register from it once the result stage can advance.
// The input register holds the sample already scaled by the conversion slope; the result
// register is loaded from the combinational conversion divide and clock/episode update.
// s_tready drops only while both stages are full and m_tready is low.
// rst is synchronous; after it the clock, episode and record counter are zero, threshold 40.
module over_temperature_episode_logger_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // adc_sample[11:0], set_value[19:12], zero fill
  input  logic [2:0]  s_tuser,   // operation[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  // temperature[8:0], over_threshold[9], clamped_low[10], clock_seconds[16:11],
  // clock_minutes[22:17], clock_hours[27:23], record_peak[36:28], record_index[44:37]
  output logic [47:0] m_tdata,
  output logic [0:0]  m_tuser,   // record_valid[0]
  input  logic        alarm_threshold_we,
  input  logic [8:0]  alarm_threshold_wdata
);

  logic                          in_valid;
  logic [otel_pkg::OP_W-1:0]     in_op;
  logic [otel_pkg::SCALED_W-1:0] in_scaled;
  logic [otel_pkg::SETV_W-1:0]   in_setv;
  logic                          out_valid;
  otel_pkg::result_t             out_result;
  otel_pkg::result_t             result;
  otel_pkg::conv_t               conv;
  logic [otel_pkg::TEMP_W-1:0]   threshold;
  logic                          advance;
  logic                          step;

  assign advance  = !out_valid || m_tready;
  assign step     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      threshold <= otel_pkg::THRESHOLD_RESET;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (step) begin
        in_valid <= 1'b0;
      end
      if (step) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      if (alarm_threshold_we) begin
        threshold <= alarm_threshold_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op     <= s_tuser;
      in_setv   <= s_tdata[19:12];
      in_scaled <= otel_pkg::SCALED_W'(s_tdata[11:0]) * otel_pkg::CONV_SLOPE;
    end
    if (step) begin
      out_result <= result;
    end
  end

  otel_convert u_convert (
    .scaled (in_scaled),
    .conv   (conv)
  );

  otel_episode u_episode (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .op        (in_op),
    .set_value (in_setv),
    .conv      (conv),
    .threshold (threshold),
    .result    (result)
  );

  assign m_tvalid = out_valid;
  assign m_tuser  = out_result.record_valid;
  assign m_tdata  = {3'b000,
                     out_result.record_index,
                     out_result.record_peak,
                     out_result.clock_hours,
                     out_result.clock_minutes,
                     out_result.clock_seconds,
                     out_result.clamped_low,
                     out_result.over_threshold,
                     out_result.temperature};

  a_record_below: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_result.record_valid |-> !out_result.over_threshold)
    else $error("record emitted on an over-threshold result");

  a_clamp_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_result.clamped_low |-> out_result.temperature == '0)
    else $error("clamped result with nonzero temperature");

  a_step_loads: assert property (@(posedge clk) disable iff (rst)
    step |=> out_valid && !$past(rst))
    else $error("processed item did not reach the result stage");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> s_tready)
    else $error("input stalled with empty result stage");

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the over-temperature episode logger core.
`timescale 1ns / 1ps

module testbench;

  localparam int CONV_NUM_OFFSET = 119705600;
  localparam int CONV_NUM_SLOPE  = 33000;
  localparam int CONV_DIVISOR    = 380928;
  localparam logic [otel_pkg::OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [otel_pkg::OP_W-1:0] OP_UNUSED_MID   = 3'd6;
  localparam logic [otel_pkg::OP_W-1:0] OP_UNUSED_LAST  = 3'd7;
  localparam logic [otel_pkg::TEMP_W-1:0] THRESHOLD_TOP = 9'd314;
  localparam logic [otel_pkg::TEMP_W-1:0] THRESHOLD_OUT = 9'd511;

  class episode_scoreboard;
    logic [otel_pkg::TEMP_W-1:0] threshold;
    logic [otel_pkg::SEC_W-1:0]  seconds;
    logic [otel_pkg::MIN_W-1:0]  minutes;
    logic [otel_pkg::HOUR_W-1:0] hours;
    logic                        in_episode;
    logic [otel_pkg::TEMP_W-1:0] peak;
    logic [otel_pkg::IDX_W-1:0]  records;
    otel_pkg::result_t           expected_q[$];
    int                          errors;

    function new();
      threshold  = otel_pkg::THRESHOLD_RESET;
      seconds    = '0;
      minutes    = '0;
      hours      = '0;
      in_episode = 1'b0;
      peak       = '0;
      records    = '0;
      errors     = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_input(logic [otel_pkg::OP_W-1:0] op,
                             logic [otel_pkg::ADC_W-1:0] adc,
                             logic [otel_pkg::SETV_W-1:0] setv);
      otel_pkg::result_t exp;
      int                scaled;
      exp = '0;
      case (op)
        otel_pkg::OP_TICK: begin
          if (seconds == otel_pkg::SEC_MAX) begin
            seconds = '0;
            if (minutes == otel_pkg::MIN_MAX) begin
              minutes = '0;
              hours   = (hours == otel_pkg::HOUR_MAX) ? '0 : hours + 1'b1;
            end else begin
              minutes = minutes + 1'b1;
            end
          end else begin
            seconds = seconds + 1'b1;
          end
          scaled = CONV_NUM_SLOPE * int'(adc);
          if (scaled > CONV_NUM_OFFSET) begin
            exp.clamped_low = 1'b1;
          end else begin
            exp.temperature = otel_pkg::TEMP_W'((CONV_NUM_OFFSET - scaled) / CONV_DIVISOR);
          end
          exp.over_threshold = (exp.temperature >= threshold);
          if (exp.over_threshold) begin
            if (!in_episode || exp.temperature > peak) peak = exp.temperature;
            in_episode = 1'b1;
          end else if (in_episode) begin
            exp.record_valid = 1'b1;
            exp.record_peak  = peak;
            exp.record_index = records;
            records          = records + 1'b1;
            in_episode       = 1'b0;
            peak             = '0;
          end
        end
        otel_pkg::OP_SET_SEC:
          seconds = (setv > otel_pkg::SEC_MAX) ? otel_pkg::SEC_MAX
                                               : setv[otel_pkg::SEC_W-1:0];
        otel_pkg::OP_SET_MIN:
          minutes = (setv > otel_pkg::MIN_MAX) ? otel_pkg::MIN_MAX
                                               : setv[otel_pkg::MIN_W-1:0];
        otel_pkg::OP_SET_HOUR:
          hours = (setv > otel_pkg::HOUR_MAX) ? otel_pkg::HOUR_MAX
                                              : setv[otel_pkg::HOUR_W-1:0];
        otel_pkg::OP_CLEAR_LOG: records = '0;
        default: ;
      endcase
      exp.clock_seconds = seconds;
      exp.clock_minutes = minutes;
      exp.clock_hours   = hours;
      expected_q.push_back(exp);
    endfunction

    task report_mismatch(string what);
      $display("%0t: mismatch: %s", $realtime, what);
      errors++;
    endtask

    task compare_field(string field, int got, int want);
      if (got != want)
        report_mismatch($sformatf("%s got %0d expected %0d", field, got, want));
    endtask

    task check_result(logic [47:0] data, logic valid_flag);
      otel_pkg::result_t exp;
      if (expected_q.size() == 0) begin
        report_mismatch("result with no input outstanding");
        return;
      end
      exp = expected_q.pop_front();
      compare_field("temperature", data[8:0], exp.temperature);
      compare_field("over_threshold", data[9], exp.over_threshold);
      compare_field("clamped_low", data[10], exp.clamped_low);
      compare_field("clock_seconds", data[16:11], exp.clock_seconds);
      compare_field("clock_minutes", data[22:17], exp.clock_minutes);
      compare_field("clock_hours", data[27:23], exp.clock_hours);
      compare_field("record_valid", valid_flag, exp.record_valid);
      compare_field("record_peak", data[36:28], exp.record_peak);
      compare_field("record_index", data[44:37], exp.record_index);
    endtask
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // adc_sample[11:0], set_value[19:12], zero fill
  logic [2:0]  s_tuser = '0;   // operation[2:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // temperature[8:0], over_threshold[9], clamped_low[10], clock_seconds[16:11],
  // clock_minutes[22:17], clock_hours[27:23], record_peak[36:28], record_index[44:37]
  logic [47:0] m_tdata;
  logic [0:0]  m_tuser;        // record_valid[0]
  logic        alarm_threshold_we = 1'b0;
  logic [8:0]  alarm_threshold_wdata = '0;

  episode_scoreboard board;
  int sent_count = 0;
  int got_count  = 0;

  over_temperature_episode_logger_core DUT (
    .clk                   (clk),
    .rst                   (rst),
    .s_tvalid              (s_tvalid),
    .s_tready              (s_tready),
    .s_tdata               (s_tdata),
    .s_tuser               (s_tuser),
    .m_tvalid              (m_tvalid),
    .m_tready              (m_tready),
    .m_tdata               (m_tdata),
    .m_tuser               (m_tuser),
    .alarm_threshold_we    (alarm_threshold_we),
    .alarm_threshold_wdata (alarm_threshold_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic send_item(logic [otel_pkg::OP_W-1:0] op,
                           logic [otel_pkg::ADC_W-1:0] adc,
                           logic [otel_pkg::SETV_W-1:0] setv);
    int gap;
    gap = ((sent_count / 50) % 4 == 1) ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0000, setv, adc};
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    board.note_input(op, adc, setv);
    sent_count++;
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (board.pending() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_threshold(logic [otel_pkg::TEMP_W-1:0] value);
    settle();
    alarm_threshold_we    <= 1'b1;
    alarm_threshold_wdata <= value;
    @(posedge clk);
    alarm_threshold_we <= 1'b0;
    board.threshold = value;
  endtask

  // hot samples at or above thr, cold below it if thr > 0; any sample if thr > 314
  function automatic logic [otel_pkg::ADC_W-1:0] sample_near(int thr, bit hot);
    int edge_adc;
    int pick;
    if (thr > int'(THRESHOLD_TOP)) return otel_pkg::ADC_W'($urandom_range(0, 4095));
    edge_adc = (CONV_NUM_OFFSET - thr * CONV_DIVISOR) / CONV_NUM_SLOPE;
    if (hot) begin
      pick = edge_adc - int'($urandom_range(0, 40));
      if (pick < 0) pick = 0;
    end else begin
      pick = edge_adc + int'($urandom_range(1, 60));
      if (pick > 4095) pick = 4095;
    end
    return otel_pkg::ADC_W'(pick);
  endfunction

  task automatic run_phase(int thr, int count, bit alternate);
    logic [otel_pkg::ADC_W-1:0]  adc;
    logic [otel_pkg::SETV_W-1:0] setv;
    logic [otel_pkg::OP_W-1:0]   op;
    int                          pick;
    int                          top;
    for (int i = 0; i < count; i++) begin
      adc  = otel_pkg::ADC_W'($urandom_range(0, 4095));
      setv = otel_pkg::SETV_W'($urandom_range(0, 255));
      if (alternate) begin
        op  = otel_pkg::OP_TICK;
        adc = sample_near(thr, (i % 2) == 0);
      end else if ($urandom_range(0, 99) < 72) begin
        op = otel_pkg::OP_TICK;
        if ($urandom_range(0, 9) >= 4) adc = sample_near(thr, 1'($urandom_range(0, 1)));
      end else begin
        pick = $urandom_range(0, 19);
        if (pick < 6) op = otel_pkg::OP_SET_SEC;
        else if (pick < 12) op = otel_pkg::OP_SET_MIN;
        else if (pick < 17) op = otel_pkg::OP_SET_HOUR;
        else if (pick == 17) op = otel_pkg::OP_CLEAR_LOG;
        else op = otel_pkg::OP_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
        top = (op == otel_pkg::OP_SET_HOUR) ? int'(otel_pkg::HOUR_MAX)
                                            : int'(otel_pkg::SEC_MAX);
        if ($urandom_range(0, 1)) setv = otel_pkg::SETV_W'($urandom_range(top - 4, top + 4));
      end
      send_item(op, adc, setv);
    end
  endtask

  initial begin
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = ((got_count / 40) % 4 == 2) ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      board.check_result(m_tdata, m_tuser[0]);
      got_count++;
    end
  end

  initial begin
    logic [otel_pkg::TEMP_W-1:0] thr;
    board = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    send_item(otel_pkg::OP_TICK, 12'd0, 8'hFF);
    send_item(otel_pkg::OP_TICK, 12'd4095, 8'h00);
    send_item(otel_pkg::OP_TICK, 12'd3627, 8'hAA);
    send_item(otel_pkg::OP_TICK, 12'd3628, 8'h55);
    send_item(otel_pkg::OP_TICK, 12'd3165, 8'h00);
    send_item(otel_pkg::OP_TICK, 12'd3166, 8'h00);
    send_item(otel_pkg::OP_SET_SEC, 12'd0, 8'd59);
    send_item(otel_pkg::OP_SET_MIN, 12'd0, 8'd60);
    send_item(otel_pkg::OP_SET_HOUR, 12'd0, 8'd255);
    send_item(otel_pkg::OP_TICK, 12'd4095, 8'h00);
    send_item(otel_pkg::OP_SET_SEC, 12'hFFF, 8'd255);
    send_item(otel_pkg::OP_SET_MIN, 12'd0, 8'd255);
    send_item(otel_pkg::OP_SET_HOUR, 12'd0, 8'd24);
    send_item(otel_pkg::OP_TICK, 12'd1000, 8'h00);
    send_item(otel_pkg::OP_CLEAR_LOG, 12'd0, 8'h00);
    send_item(otel_pkg::OP_TICK, 12'd3000, 8'h00);
    send_item(otel_pkg::OP_TICK, 12'd4000, 8'h00);
    send_item(otel_pkg::OP_SET_HOUR, 12'd0, 8'd0);
    send_item(OP_UNUSED_FIRST, 12'hFFF, 8'hFF);
    send_item(OP_UNUSED_MID, 12'd0, 8'h00);
    send_item(OP_UNUSED_LAST, 12'hABC, 8'h12);
    send_item(otel_pkg::OP_SET_SEC, 12'd0, 8'd0);

    write_threshold(otel_pkg::THRESHOLD_RESET);
    run_phase(int'(otel_pkg::THRESHOLD_RESET), 530, 1'b1);
    write_threshold(THRESHOLD_TOP);
    run_phase(int'(THRESHOLD_TOP), 180, 1'b0);
    write_threshold('0);
    run_phase(0, 150, 1'b0);
    write_threshold(THRESHOLD_OUT);
    run_phase(int'(THRESHOLD_OUT), 120, 1'b0);
    repeat (4) begin
      thr = otel_pkg::TEMP_W'($urandom_range(1, 313));
      write_threshold(thr);
      run_phase(int'(thr), 200, 1'b0);
    end

    settle();
    repeat (8) @(posedge clk);
    if (board.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/otel_pkg.sv
hdl/otel_convert.sv
hdl/otel_episode.sv
hdl/over_temperature_episode_logger_core.sv
sim/testbench.sv
